>>> hw/rtl/gtlj_pkg.sv
// Package for the greedy text line justifier: widths, constants, state enum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gtlj_pkg;
  localparam int MAX_LINE_WIDTH = 32;
  localparam logic [7:0] SPACE_CODE = 8'd32;
  localparam logic [5:0] WIDTH_RESET = 6'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_EMIT,
    ST_SPLIT
  } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/gtlj_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gtlj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/greedy_text_line_justifier.sv
// Greedy full-justify text formatter, top level.
// Depends on gtlj_pkg and gtlj_ram.
//
//  channel | dir | handshake     | payload
//  in_     | in  | valid / stall | ch, word_end, text_end
//  out_    | out | valid / stall | out_char, line_end, run_last
//  cfg_    | in  | valid / ready | data (max_width)
//
// A character that does not end a word is stored in idle. At a word end the
// kept characters are copied into the line store and the length is filed. A
// full line first runs the divide, then emits its output beats word by word
// and closes; the last line at end of text skips the divide.
// Reset is synchronous, active low; no clearing pass after reset. Input stalls
// outside idle and while a beat waits; a stalled output freezes the emit state.
`timescale 1ns / 1ps
`default_nettype none
module greedy_text_line_justifier #(
  parameter int MAX_LINE_WIDTH = gtlj_pkg::MAX_LINE_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_word_end,
  input  wire logic       in_text_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_out_char,
  output logic            out_line_end,
  output logic            out_run_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data
);
  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int SLOTS = (MAX_LINE_WIDTH + 1) / 2;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(MAX_LINE_WIDTH + 1) + 1;

  gtlj_pkg::state_t st_r, st_nxt;

  logic [5:0]   width_r;
  logic [CW-1:0] cw_r, cw_nxt;
  logic [CW-1:0] cl_r, cl_nxt;
  logic [SW:0]   nw_r, nw_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          te_r, te_nxt, emit2_r, emit2_nxt, last_r, last_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [SW:0]   k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] base_r, base_nxt, rem_r, rem_nxt, gaps_r, gaps_nxt;
  logic [CW-1:0] fr_r, fr_nxt;
  logic [7:0]    oc_r, oc_nxt;
  logic          ol_r, ol_nxt, orl_r, orl_nxt;
  logic          pend_r, pend_nxt;

  logic [CW-1:0] w_eff;
  always_comb begin
    if (width_r == 6'd0) w_eff = CW'(1);
    else if (32'(width_r) > MAX_LINE_WIDTH) w_eff = CW'(MAX_LINE_WIDTH);
    else w_eff = CW'(width_r);
  end

  logic          ws_we, ls_we, wl_we;
  logic [AW-1:0] ws_wa, ws_ra, ls_wa, ls_ra;
  logic [7:0]    ws_wd, ws_rd, ls_wd, ls_rd;
  logic [SW-1:0] wl_wa, wl_ra;
  logic [5:0]    wl_wd, wl_rd;

  gtlj_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_word (
    .clk(clk), .we(ws_we), .waddr(ws_wa), .wdata(ws_wd), .raddr(ws_ra), .rdata(ws_rd));
  gtlj_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_line (
    .clk(clk), .we(ls_we), .waddr(ls_wa), .wdata(ls_wd), .raddr(ls_ra), .rdata(ls_rd));
  gtlj_ram #(.WIDTH(6), .DEPTH(SLOTS)) u_len (
    .clk(clk), .we(wl_we), .waddr(wl_wa), .wdata(wl_wd), .raddr(wl_ra), .rdata(wl_rd));

  // forward a write that lands on the entry being read in the same cycle
  logic       ws_hit_r, wl_hit_r;
  logic [7:0] ws_hd_r, ws_q;
  logic [5:0] wl_hd_r, wl_q;
  assign ws_q = ws_hit_r ? ws_hd_r : ws_rd;
  assign wl_q = wl_hit_r ? wl_hd_r : wl_rd;

  logic in_acc, out_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !pend_r || out_acc;
  assign in_stall = (st_r != gtlj_pkg::ST_IDLE) || (pend_r && !out_acc);
  assign cfg_ready = 1'b1;
  assign out_valid = pend_r;
  assign out_out_char = oc_r;
  assign out_line_end = ol_r;
  assign out_run_last = orl_r;

  logic [CW-1:0] cwi, lenw, fitsum;
  logic          fits;

  always_comb begin
    st_nxt = st_r; cw_nxt = cw_r; cl_nxt = cl_r; nw_nxt = nw_r; len_nxt = len_r;
    te_nxt = te_r; emit2_nxt = emit2_r; last_nxt = last_r;
    src_nxt = src_r; pos_nxt = pos_r; k_nxt = k_r; j_nxt = j_r; sp_nxt = sp_r;
    base_nxt = base_r; rem_nxt = rem_r; gaps_nxt = gaps_r; fr_nxt = fr_r;
    oc_nxt = oc_r; ol_nxt = ol_r; orl_nxt = orl_r;
    pend_nxt = pend_r && !out_acc;
    ws_we = 1'b0; ws_wa = cw_r[AW-1:0]; ws_wd = in_ch; ws_ra = '0;
    ls_we = 1'b0; ls_wa = '0; ls_wd = ws_q; ls_ra = src_r[AW-1:0];
    wl_we = 1'b0; wl_wa = nw_r[SW-1:0]; wl_wd = len_r[5:0]; wl_ra = k_r[SW-1:0];
    cwi = cw_r; lenw = '0; fitsum = '0; fits = 1'b0;
    unique case (st_r)
      gtlj_pkg::ST_IDLE: begin
        if (in_acc) begin
          cwi = cw_r;
          if (cw_r < w_eff) begin
            ws_we = 1'b1;
            cwi = cw_r + CW'(1);
          end
          if (in_word_end || in_text_end) begin
            lenw = (cwi > w_eff) ? w_eff : cwi;
            fitsum = cl_r + lenw + CW'(nw_r);
            fits = (32'(nw_r) < SLOTS) && (fitsum <= w_eff);
            cw_nxt = '0;
            len_nxt = lenw;
            te_nxt = in_text_end;
            emit2_nxt = !fits && (nw_r != '0);
            if (!fits) begin
              // hold the old line until emitted, then the word goes to slot 0
              if (nw_r == '0) begin
                cl_nxt = '0;
              end
            end
            j_nxt = '0;
            ws_ra = '0;
            if (emit2_nxt) begin
              last_nxt = 1'b0;
              st_nxt = gtlj_pkg::ST_SPLIT;
            end else begin
              st_nxt = gtlj_pkg::ST_COPY;
            end
            gaps_nxt = (nw_r > 0) ? CW'(nw_r) - CW'(1) : '0;
            fr_nxt = (w_eff > cl_r) ? w_eff - cl_r : '0;
            base_nxt = '0;
            rem_nxt = '0;
          end else begin
            cw_nxt = cwi;
          end
        end
      end
      gtlj_pkg::ST_SPLIT: begin
        // repeated subtraction: base = free / gaps, rem = free % gaps
        if (gaps_r != '0 && fr_r >= gaps_r) begin
          fr_nxt = fr_r - gaps_r;
          base_nxt = base_r + CW'(1);
        end else begin
          rem_nxt = (gaps_r != '0) ? fr_r : '0;
          k_nxt = '0; j_nxt = '0; src_nxt = '0; pos_nxt = '0;
          sp_nxt = '0;
          wl_ra = '0;
          ls_ra = '0;
          st_nxt = gtlj_pkg::ST_EMIT;
        end
      end
      gtlj_pkg::ST_COPY: begin
        // move one word character per cycle; read data of index j arrives
        ws_ra = j_r[AW-1:0] + AW'(1);
        if (j_r < len_r) begin
          if (32'(cl_r + j_r) < MAX_LINE_WIDTH) begin
            ls_we = 1'b1;
            ls_wa = AW'(cl_r + j_r);
          end
          j_nxt = j_r + CW'(1);
        end else begin
          wl_we = 1'b1;
          nw_nxt = nw_r + 1'b1;
          cl_nxt = cl_r + len_r;
          if (te_r) begin
            last_nxt = 1'b1;
            gaps_nxt = '0; base_nxt = '0; rem_nxt = '0;
            k_nxt = '0; j_nxt = '0; src_nxt = '0; pos_nxt = '0;
            sp_nxt = '0;
            wl_ra = '0; ls_ra = '0;
            st_nxt = gtlj_pkg::ST_EMIT;
          end else begin
            st_nxt = gtlj_pkg::ST_IDLE;
          end
        end
      end
      gtlj_pkg::ST_EMIT: begin
        // wl_q holds length of word k_r, ls_rd holds line_store[src_r]
        if (out_free) begin
          if (pos_r >= w_eff) begin
            nw_nxt = '0;
            cl_nxt = '0;
            if (!last_r) begin
              j_nxt = '0;
              ws_ra = '0;
              last_nxt = te_r;
              st_nxt = gtlj_pkg::ST_COPY;
            end else begin
              st_nxt = gtlj_pkg::ST_IDLE;
            end
          end else begin
            pend_nxt = 1'b1;
            ol_nxt = (pos_r + CW'(1) == w_eff);
            orl_nxt = ol_nxt && (last_r || !te_r);
            pos_nxt = pos_r + CW'(1);
            if (k_r < nw_r && 32'(k_r) < SLOTS && j_r < CW'(wl_q)) begin
              oc_nxt = (32'(src_r) < MAX_LINE_WIDTH) ? ls_rd : 8'd0;
              src_nxt = src_r + CW'(1);
              j_nxt = j_r + CW'(1);
              ls_ra = AW'(src_r + CW'(1));
              if (j_r + CW'(1) == CW'(wl_q)) begin
                sp_nxt = last_r ? CW'(1)
                                : base_r + ((CW'(k_r) < rem_r) ? CW'(1) : CW'(0));
                if (k_r + 1'b1 >= nw_r) begin
                  sp_nxt = '0;
                end
              end
            end else if (sp_r != '0) begin
              oc_nxt = gtlj_pkg::SPACE_CODE;
              sp_nxt = sp_r - CW'(1);
            end else if (k_r < nw_r && 32'(k_r) < SLOTS) begin
              // advance to next word; no output yet this cycle
              pend_nxt = pend_r && !out_acc;
              pos_nxt = pos_r;
              ol_nxt = ol_r;
              orl_nxt = orl_r;
              k_nxt = k_r + 1'b1;
              j_nxt = '0;
              wl_ra = SW'(k_r + 1'b1);
            end else begin
              oc_nxt = gtlj_pkg::SPACE_CODE;
            end
          end
        end
      end
      default: st_nxt = gtlj_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gtlj_pkg::ST_IDLE;
      width_r <= gtlj_pkg::WIDTH_RESET;
      cw_r <= '0; cl_r <= '0; nw_r <= '0; pend_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) width_r <= cfg_data;
      st_r <= st_nxt; cw_r <= cw_nxt; cl_r <= cl_nxt; nw_r <= nw_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt; te_r <= te_nxt; emit2_r <= emit2_nxt; last_r <= last_nxt;
    src_r <= src_nxt; pos_r <= pos_nxt; k_r <= k_nxt;
    j_r <= j_nxt; sp_r <= sp_nxt; base_r <= base_nxt; rem_r <= rem_nxt;
    gaps_r <= gaps_nxt; fr_r <= fr_nxt;
    oc_r <= oc_nxt; ol_r <= ol_nxt; orl_r <= orl_nxt;
    ws_hit_r <= ws_we && (ws_wa == ws_ra); ws_hd_r <= ws_wd;
    wl_hit_r <= wl_we && (wl_wa == wl_ra); wl_hd_r <= wl_wd;
  end
endmodule
`default_nettype wire

>>> hw/rtl/gtlj_checker.sv
// Port-level checker for the greedy text line justifier, bound to the top.
// Depends on greedy_text_line_justifier ports only.
`timescale 1ns / 1ps
`default_nettype none
module gtlj_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_out_char,
  input wire logic       out_line_end,
  input wire logic       out_run_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_char))
    else $error("stalled beat changed");
  a_rl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_line_end)
    else $error("run_last off a line end");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_end |-> in_stall)
    else $error("input taken mid line");
endmodule

bind greedy_text_line_justifier gtlj_checker u_gtlj_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_out_char(out_out_char),
  .out_line_end(out_line_end), .out_run_last(out_run_last));
`default_nettype wire

>>> test/tb_top.sv
// Testbench for greedy_text_line_justifier: a line-filling predictor checks
// every output beat against the justified lines that the sent text implies.
// Depends on gtlj_pkg and the justifier RTL.
`timescale 1ns / 1ps
module tb_top;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_LEN = 400;
  localparam int SLOTS = (gtlj_pkg::MAX_LINE_WIDTH + 1) / 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       run_last;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = 8'd0;
  logic       in_word_end = 1'b0;
  logic       in_text_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_char;
  logic       out_line_end;
  logic       out_run_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = 6'd0;

  greedy_text_line_justifier i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch),
    .in_word_end(in_word_end), .in_text_end(in_text_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_out_char(out_out_char),
    .out_line_end(out_line_end), .out_run_last(out_run_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [5:0] width_reg = gtlj_pkg::WIDTH_RESET;
  logic [7:0] line_chars[gtlj_pkg::MAX_LINE_WIDTH];
  logic [7:0] word_chars[gtlj_pkg::MAX_LINE_WIDTH];
  int         word_lens[SLOTS];
  int         n_words = 0;
  int         n_line_chars = 0;
  int         n_word_chars = 0;
  out_beat_t  line_beats_q[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > gtlj_pkg::MAX_LINE_WIDTH) return gtlj_pkg::MAX_LINE_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic void justify_line(input int w, input bit last);
    logic [7:0] buf_c[gtlj_pkg::MAX_LINE_WIDTH];
    int pos, src, gaps, free_sp, base, rem, sp;
    out_beat_t b;
    pos = 0;
    src = 0;
    gaps = n_words > 0 ? n_words - 1 : 0;
    free_sp = w > n_line_chars ? w - n_line_chars : 0;
    base = gaps ? free_sp / gaps : 0;
    rem = gaps ? free_sp % gaps : 0;
    for (int k = 0; k < n_words && k < SLOTS; k++) begin
      for (int j = 0; j < word_lens[k]; j++) begin
        if (src < gtlj_pkg::MAX_LINE_WIDTH && pos < w) begin
          buf_c[pos] = line_chars[src];
          pos++;
        end
        src++;
      end
      if (k + 1 < n_words) begin
        sp = last ? 1 : base + (k < rem ? 1 : 0);
        for (int j = 0; j < sp; j++)
          if (pos < w) begin
            buf_c[pos] = gtlj_pkg::SPACE_CODE;
            pos++;
          end
      end
    end
    while (pos < w) begin
      buf_c[pos] = gtlj_pkg::SPACE_CODE;
      pos++;
    end
    for (int j = 0; j < w; j++) begin
      b.ch = buf_c[j];
      b.line_end = (j + 1 == w);
      b.run_last = 1'b0;
      line_beats_q = {line_beats_q, b};
    end
    n_words = 0;
    n_line_chars = 0;
  endfunction

  function automatic void predict_char(input logic [7:0] c, input bit we_in, input bit te);
    int w, len, n_prior;
    bit we;
    out_beat_t b;
    w = eff_width();
    we = we_in | te;
    n_prior = line_beats_q.size();
    if (n_word_chars < w) begin
      word_chars[n_word_chars] = c;
      n_word_chars++;
    end
    if (we) begin
      len = n_word_chars > w ? w : n_word_chars;
      n_word_chars = 0;
      if (!(n_words < SLOTS && n_line_chars + len + n_words <= w)) begin
        if (n_words > 0) justify_line(w, 1'b0);
        n_words = 0;
        n_line_chars = 0;
      end
      for (int j = 0; j < len; j++)
        if (n_line_chars + j < gtlj_pkg::MAX_LINE_WIDTH)
          line_chars[n_line_chars + j] = word_chars[j];
      word_lens[n_words] = len;
      n_words++;
      n_line_chars += len;
      if (te) justify_line(w, 1'b1);
    end
    if (line_beats_q.size() > n_prior) begin
      b = line_beats_q[$];
      b.run_last = 1'b1;
      line_beats_q[line_beats_q.size() - 1] = b;
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input bit we, input bit te);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_word_end <= we;
    in_text_end <= te;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c, we, te);
  endtask

  task automatic send_word(input int len, input bit te);
    for (int i = 0; i < len; i++)
      send_char(8'($urandom_range(255)), i == len - 1, te && (i == len - 1));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (line_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [5:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_reg = v;
  endtask

  task automatic send_text(input int n, input bit finish);
    int len;
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(9) == 0) ? int'($urandom_range(eff_width() + 4, 1))
                                     : int'($urandom_range(eff_width() > 6 ? 6 : eff_width(), 1));
      send_word(len, finish && i == n - 1);
    end
  endtask

  task automatic test_directed();
    send_char(8'd0, 1'b0, 1'b0);
    send_char(8'd255, 1'b1, 1'b0);
    send_word(16, 1'b0);
    send_word(3, 1'b0);
    send_char(8'hAA, 1'b0, 1'b1);
    write_width(6'd1);
    send_word(3, 1'b0);
    send_word(1, 1'b1);
    write_width(6'd32);
    send_word(1, 1'b0);
    send_word(1, 1'b0);
    send_word(35, 1'b1);
    write_width(6'd0);
    send_word(2, 1'b1);
    write_width(6'd63);
    send_word(4, 1'b0);
    send_word(5, 1'b1);
  endtask

  task automatic test_random_phases();
    logic [5:0] widths[4] = '{6'd16, 6'd5, 6'd32, 6'd11};
    int idle_modes[4] = '{0, 76, 0, 76};
    int stall_modes[4] = '{0, 0, 76, 76};
    for (int p = 0; p < 4; p++) begin
      write_width(widths[p]);
      send_idle_pct = idle_modes[p];
      stall_pct = stall_modes[p];
      if (p == 3) begin
        send_idle_pct = 16;
        stall_pct = 16;
      end
      send_text(5, p != 1);
      send_text(4, 1'b1);
      for (int i = 0; i < 4; i++)
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(5) == 0);
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_width(6'd8);
    hold_req++;
    send_text(14, 1'b1);
  endtask

  task automatic test_pause();
    write_width(6'd12);
    send_text(3, 1'b0);
    drain();
    send_text(3, 1'b1);
    write_width(6'd20);
    send_text(6, 1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (line_beats_q.size() == 0) begin
        report($sformatf("unexpected beat char %0d", out_out_char));
      end else begin
        exp_b = line_beats_q.pop_front();
        if (out_out_char !== exp_b.ch)
          report($sformatf("out_char %0d, expected %0d", out_out_char, exp_b.ch));
        if (out_line_end !== exp_b.line_end)
          report($sformatf("line_end %0b, expected %0b", out_line_end, exp_b.line_end));
        if (out_run_last !== exp_b.run_last)
          report($sformatf("run_last %0b, expected %0b", out_run_last, exp_b.run_last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    test_pause();
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
